/* rtl/ilaa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilaa_pkg: shared types and constants for the interval-label argmax block
// Class count, field widths, function codes, the token that travels along the
// row of cells, and the loss helpers.
// ----------------------------------------------------------------------------
package ilaa_pkg;

    localparam int MAX_CLASSES = 64;
    localparam int IDX_W       = $clog2(MAX_CLASSES); // class index width
    localparam int NCL_W       = IDX_W + 1;        // holds the class count itself
    localparam int LBL_W       = 6;                // label and result index fields
    localparam int DAT_W       = 32;               // Q16.16 beta and score
    localparam int ACC_W       = DAT_W + IDX_W;    // wx * y
    localparam int COST_W      = ACC_W + 2;        // wx * y + beta + loss
    localparam int RISK_W      = 48;
    localparam int COEF_W      = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DAT_W   = 7;

    typedef enum logic [1:0] {
        FN_WRITE = 2'd0,
        FN_EVAL  = 2'd1,
        FN_PRED  = 2'd2
    } t_func;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOSS_KIND   = 1'b1;

    localparam logic LOSS_ABS     = 1'b0;
    localparam logic LOSS_ZERO_ONE = 1'b1;

    // One request in flight along the row; each cell folds in its class.
    typedef struct packed {
        logic                     vld;
        logic                     pred;   // predict, otherwise evaluate
        logic                     bad;    // labels rejected at entry
        logic                     lkind;
        logic signed [DAT_W-1:0]  wx;
        logic signed [ACC_W-1:0]  acc;    // wx * (index of the receiving cell)
        logic [LBL_W-1:0]         lo;
        logic [LBL_W-1:0]         hi;
        logic [NCL_W-1:0]         ncls;
        logic signed [COST_W-1:0] lcost;
        logic [IDX_W-1:0]         lidx;
        logic signed [COST_W-1:0] rcost;
        logic [IDX_W-1:0]         ridx;
        logic signed [COST_W-1:0] sub;    // costs of the true labels, no loss
    } t_tok;

    function automatic logic [IDX_W-1:0] unit_loss(input logic kind,
                                                   input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b);
        logic [IDX_W-1:0] res;
        if (kind == LOSS_ZERO_ONE) begin
            res = IDX_W'(a != b);
        end else if (a > b) begin
            res = a - b;
        end else begin
            res = b - a;
        end
        return res;
    endfunction

    // Whole loss units to Q16.16 at cost width.
    function automatic logic signed [COST_W-1:0] loss_q(input logic [IDX_W-1:0] l);
        return signed'(COST_W'({l, 16'h0000}));
    endfunction

endpackage

/* rtl/interval_label_loss_augmented_argmax_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_label_loss_augmented_argmax_top: loss-augmented argmax, interval labels
// Ordinal-regression argmax over a row of class cells with per-class beta.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                  payload
//  -------  ---------  -------------------------  --------------------------------
//  in       to block   i_in_valid / o_in_ready    func, class_index, beta_value,
//                                                 wx_score, label_low, label_high
//  out      from block o_out_valid / i_out_ready  best_low, best_high,
//                                                 gradient_coef, risk_value,
//                                                 predicted_class,
//                                                 prediction_loss, status
//  cfg      to block   i_cfg_valid / o_cfg_ready  cfg_index, cfg_data
//
//  A beta write updates its entry when accepted. An evaluate or predict request
//  walks the row of MAX_CLASSES cells, one cell per cycle while a stalled output
//  does not hold the row, then lands in the output register; the next request
//  can enter only once the result is there.
//  Reset clears the class count to 64 and the loss to absolute difference;
//  beta entries are undefined until written. A stalled output holds the
//  finished request at the end of the row; writes are taken whenever no scan
//  is in flight, also while a result waits.
//
module interval_label_loss_augmented_argmax_top import ilaa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_func,
    input  logic [LBL_W-1:0]         i_class_index,
    input  logic signed [DAT_W-1:0]  i_beta_value,
    input  logic signed [DAT_W-1:0]  i_wx_score,
    input  logic [LBL_W-1:0]         i_label_low,
    input  logic [LBL_W-1:0]         i_label_high,
    // result channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [LBL_W-1:0]         o_best_low,
    output logic [LBL_W-1:0]         o_best_high,
    output logic signed [COEF_W-1:0] o_gradient_coef,
    output logic signed [RISK_W-1:0] o_risk_value,
    output logic [LBL_W-1:0]         o_predicted_class,
    output logic [LBL_W-1:0]         o_prediction_loss,
    output logic                     o_status,
    // configuration channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DAT_W-1:0]     i_cfg_data
);

    logic [CFG_DAT_W-1:0] r_num_classes;
    logic                 r_loss_kind;
    logic                 r_busy;
    logic                 in_acc;
    logic                 is_scan;
    logic                 adv;
    logic                 done;
    logic [NCL_W-1:0]     ncls;
    logic                 bad;
    t_func                func;
    t_tok                 head;
    t_tok                 tok [MAX_CLASSES+1];
    logic [MAX_CLASSES-1:0] cell_vld;

    // One scan in flight at a time; beta writes wait for the row to drain.
    assign o_in_ready  = !r_busy;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign func        = t_func'(i_func);

    // Clamp the class count to 2..MAX_CLASSES.
    always_comb begin
        if (NCL_W'(r_num_classes) < NCL_W'(2)) begin
            ncls = NCL_W'(2);
        end else if (NCL_W'(r_num_classes) > NCL_W'(MAX_CLASSES)) begin
            ncls = NCL_W'(MAX_CLASSES);
        end else begin
            ncls = NCL_W'(r_num_classes);
        end
    end

    always_comb begin
        case (func)
            FN_EVAL: begin
                is_scan = 1'b1;
                bad     = (i_label_low > i_label_high) || (NCL_W'(i_label_high) >= ncls);
            end
            FN_PRED: begin
                is_scan = 1'b1;
                bad     = NCL_W'(i_label_low) >= ncls;
            end
            default: begin
                is_scan = 1'b0;
                bad     = 1'b0;
            end
        endcase
    end

    // Seed the request: cell 0 sees wx * 0, running costs start empty.
    always_comb begin
        head.vld   = in_acc && is_scan;
        head.pred  = (func == FN_PRED);
        head.bad   = bad;
        head.lkind = r_loss_kind;
        head.wx    = i_wx_score;
        head.acc   = '0;
        head.lo    = i_label_low;
        head.hi    = i_label_high;
        head.ncls  = ncls;
        head.lcost = '0;
        head.lidx  = '0;
        head.rcost = '0;
        head.ridx  = IDX_W'(i_label_high);
        head.sub   = '0;
    end

    assign tok[0] = head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_classes <= CFG_DAT_W'(MAX_CLASSES);
            r_loss_kind   <= LOSS_ABS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_NUM_CLASSES: r_num_classes <= i_cfg_data;
                CFG_LOSS_KIND:   r_loss_kind   <= i_cfg_data[0];
                default:         r_loss_kind   <= r_loss_kind;
            endcase
        end
    end

    // Busy from scan entry until the result reaches the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (head.vld) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    // Row of class cells: cell k scores class k and passes the request on.
    for (genvar k = 0; k < MAX_CLASSES; k++) begin : g_cell
        ilaa_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_cls     (IDX_W'(k)),
            .i_wr_en   (in_acc && (func == FN_WRITE)),
            .i_wr_idx  (i_class_index),
            .i_wr_data (i_beta_value),
            .i_tok     (tok[k]),
            .o_tok     (tok[k+1])
        );
        assign cell_vld[k] = tok[k+1].vld;
    end

    ilaa_fin u_fin (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tok             (tok[MAX_CLASSES]),
        .o_adv             (adv),
        .o_done            (done),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_best_low        (o_best_low),
        .o_best_high       (o_best_high),
        .o_gradient_coef   (o_gradient_coef),
        .o_risk_value      (o_risk_value),
        .o_predicted_class (o_predicted_class),
        .o_prediction_loss (o_prediction_loss),
        .o_status          (o_status)
    );

    // At most one request travels the row.
    a_one_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(cell_vld) <= 1)
        else $error("more than one request in the cell row");

    // Ready means the row is empty.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (cell_vld == '0))
        else $error("request accepted while the row is occupied");

    // A scan entry holds off the next request.
    a_entry_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        head.vld |=> r_busy)
        else $error("busy not raised on scan entry");

    // Retiring a request frees the input and fills the output.
    a_retire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> (!r_busy && o_out_valid))
        else $error("retired request did not reach the output");

endmodule

/* rtl/ilaa_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilaa_cell: one class of the scan row
// Holds the beta entry of its class, folds its cost into the running argmax
// of the passing request and hands the request to the next cell.
// ----------------------------------------------------------------------------
module ilaa_cell import ilaa_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic [IDX_W-1:0]        i_cls,
    input  logic                    i_wr_en,
    input  logic [LBL_W-1:0]        i_wr_idx,
    input  logic signed [DAT_W-1:0] i_wr_data,
    input  t_tok                    i_tok,
    output t_tok                    o_tok
);

    logic signed [DAT_W-1:0]  r_beta;
    t_tok                     r_tok;
    t_tok                     n_tok;
    logic signed [COST_W-1:0] base;
    logic signed [COST_W-1:0] costl;
    logic signed [COST_W-1:0] costr;
    logic [IDX_W-1:0]         lox;
    logic [IDX_W-1:0]         hix;
    logic                     in_cnt;
    logic                     in_l;
    logic                     in_r;

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (IDX_W'(i_wr_idx) == i_cls)) begin
            r_beta <= i_wr_data;
        end
    end

    always_comb begin
        lox    = IDX_W'(i_tok.lo);
        hix    = IDX_W'(i_tok.hi);
        base   = COST_W'(i_tok.acc) + COST_W'(r_beta);
        costl  = i_tok.pred ? base : base + loss_q(unit_loss(i_tok.lkind, i_cls, lox));
        costr  = base + loss_q(unit_loss(i_tok.lkind, i_cls, hix));
        in_cnt = {1'b0, i_cls} < i_tok.ncls;
        in_l   = i_tok.pred ? in_cnt : (i_cls <= lox);
        in_r   = !i_tok.pred && in_cnt && (i_cls >= hix);

        n_tok     = i_tok;
        n_tok.acc = i_tok.acc + ACC_W'(i_tok.wx);
        // strict compare keeps the first maximum
        if (in_l && ((i_cls == '0) || (costl > i_tok.lcost))) begin
            n_tok.lcost = costl;
            n_tok.lidx  = i_cls;
        end
        if (in_r && ((i_cls == hix) || (costr > i_tok.rcost))) begin
            n_tok.rcost = costr;
            n_tok.ridx  = i_cls;
        end
        if ((i_cls == lox) && (i_cls == hix)) begin
            n_tok.sub = i_tok.sub + base + base;
        end else if ((i_cls == lox) || (i_cls == hix)) begin
            n_tok.sub = i_tok.sub + base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

/* rtl/ilaa_fin.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilaa_fin: result stage
// Forms gradient coefficient, risk and prediction loss from the finished
// request and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ilaa_fin import ilaa_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_tok                     i_tok,
    output logic                     o_adv,
    output logic                     o_done,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [LBL_W-1:0]         o_best_low,
    output logic [LBL_W-1:0]         o_best_high,
    output logic signed [COEF_W-1:0] o_gradient_coef,
    output logic signed [RISK_W-1:0] o_risk_value,
    output logic [LBL_W-1:0]         o_predicted_class,
    output logic [LBL_W-1:0]         o_prediction_loss,
    output logic                     o_status
);

    logic                     r_out_valid;
    logic [LBL_W-1:0]         r_best_low;
    logic [LBL_W-1:0]         r_best_high;
    logic signed [COEF_W-1:0] r_coef;
    logic signed [RISK_W-1:0] r_risk;
    logic [LBL_W-1:0]         r_pclass;
    logic [LBL_W-1:0]         r_ploss;
    logic                     r_status;
    logic [IDX_W+2:0]         coef_sum;
    logic signed [RISK_W-1:0] risk;
    logic [IDX_W-1:0]         ploss;

    // hold the row only while a finished request meets a full, stalled output
    assign o_adv  = !(i_tok.vld && r_out_valid && !i_out_ready);
    assign o_done = i_tok.vld && o_adv;

    always_comb begin
        coef_sum = (IDX_W+3)'(i_tok.lidx) + (IDX_W+3)'(i_tok.ridx)
                 - (IDX_W+3)'(i_tok.lo) - (IDX_W+3)'(i_tok.hi);
        risk     = RISK_W'(i_tok.lcost) + RISK_W'(i_tok.rcost) - RISK_W'(i_tok.sub);
        ploss    = unit_loss(i_tok.lkind, IDX_W'(i_tok.lo), i_tok.lidx);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_done) begin
            r_best_low  <= '0;
            r_best_high <= '0;
            r_coef      <= '0;
            r_risk      <= '0;
            r_pclass    <= '0;
            r_ploss     <= '0;
            r_status    <= i_tok.bad;
            if (!i_tok.bad && i_tok.pred) begin
                r_pclass <= i_tok.lidx[LBL_W-1:0];
                r_ploss  <= ploss[LBL_W-1:0];
            end else if (!i_tok.bad) begin
                r_best_low  <= i_tok.lidx[LBL_W-1:0];
                r_best_high <= i_tok.ridx[LBL_W-1:0];
                r_coef      <= signed'(coef_sum[COEF_W-1:0]);
                r_risk      <= risk;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_best_low        = r_best_low;
    assign o_best_high       = r_best_high;
    assign o_gradient_coef   = r_coef;
    assign o_risk_value      = r_risk;
    assign o_predicted_class = r_pclass;
    assign o_prediction_loss = r_ploss;
    assign o_status          = r_status;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the interval-label loss-augmented argmax
// Loads the beta table, then runs directed requests on the field extremes,
// ties, bad labels and clamped class counts. After that come randomized phases
// under several register settings, with random idling on both channels, one
// long output stall and one full drain. A scoreboard class predicts every
// result and compares it field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
    import ilaa_pkg::*;

    localparam int SETTLE      = MAX_CLASSES + 8;   // covers the row walk of a late request
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]              func;
        logic [LBL_W-1:0]        cls;
        logic signed [DAT_W-1:0] beta;
        logic signed [DAT_W-1:0] wx;
        logic [LBL_W-1:0]        lo;
        logic [LBL_W-1:0]        hi;
    } t_request;

    typedef struct packed {
        logic [LBL_W-1:0]         best_low;
        logic [LBL_W-1:0]         best_high;
        logic signed [COEF_W-1:0] coef;
        logic signed [RISK_W-1:0] risk;
        logic [LBL_W-1:0]         pred_class;
        logic [LBL_W-1:0]         pred_loss;
        logic                     status;
    } t_outcome;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of beta table and registers, queue of outcomes due
    // ------------------------------------------------------------------------
    class argmax_scoreboard;
        logic signed [DAT_W-1:0] beta_q [MAX_CLASSES];
        logic [CFG_DAT_W-1:0]    class_reg;
        logic                    loss_reg;
        t_outcome                pending_outcomes [$];
        int                      errors;

        function new();
            class_reg = CFG_DAT_W'(MAX_CLASSES);
            loss_reg  = LOSS_ABS;
            errors    = 0;
            foreach (beta_q[k]) beta_q[k] = '0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] val);
            if (idx == CFG_NUM_CLASSES) begin
                class_reg = val;
            end else begin
                loss_reg = val[0];
            end
        endfunction

        function int class_span();
            if (class_reg < 2) return 2;
            if (class_reg > MAX_CLASSES) return MAX_CLASSES;
            return int'(class_reg);
        endfunction

        function int rank_loss(input int a, input int b);
            if (loss_reg == LOSS_ZERO_ONE) return (a != b) ? 1 : 0;
            return (a > b) ? a - b : b - a;
        endfunction

        // Strict compare keeps the lowest class among equal costs.
        function int best_of(input int first, input int last, input int truth,
                             input bit with_loss, input longint wx,
                             output longint top);
            int     best;
            longint c;
            best = first;
            top  = 0;
            for (int y = first; y <= last; y++) begin
                c = wx * longint'(y) + longint'(beta_q[y]);
                if (with_loss) c += longint'(rank_loss(y, truth)) * 65536;
                if (y == first || c > top) begin
                    top  = c;
                    best = y;
                end
            end
            return best;
        endfunction

        // Update the table on a write, queue the outcome of an evaluate or predict.
        function void accept_request(input t_request r);
            t_outcome o;
            int       n, bl, bh, p, lo, hi;
            longint   cl, cr, wx, risk;
            if (r.func == FN_WRITE) begin
                beta_q[r.cls] = r.beta;
                return;
            end
            if (r.func == FN_UNUSED) return;
            o  = '0;
            n  = class_span();
            lo = int'(r.lo);
            hi = int'(r.hi);
            wx = longint'(r.wx);
            if (r.func == FN_EVAL) begin
                if (lo > hi || hi >= n) begin
                    o.status = 1'b1;
                end else begin
                    bl   = best_of(0, lo, lo, 1'b1, wx, cl);
                    bh   = best_of(hi, n - 1, hi, 1'b1, wx, cr);
                    risk = cl + cr - (wx * longint'(lo + hi) + longint'(beta_q[lo])
                                      + longint'(beta_q[hi]));
                    o.best_low  = LBL_W'(bl);
                    o.best_high = LBL_W'(bh);
                    o.coef      = COEF_W'(bl + bh - lo - hi);
                    o.risk      = RISK_W'(risk);
                end
            end else begin
                if (lo >= n) begin
                    o.status = 1'b1;
                end else begin
                    p = best_of(0, n - 1, 0, 1'b0, wx, cl);
                    o.pred_class = LBL_W'(p);
                    o.pred_loss  = LBL_W'(rank_loss(lo, p));
                end
            end
            pending_outcomes.push_back(o);
        endfunction

        function void report(input string what, input longint got, input longint want);
            $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
            errors++;
        endfunction

        function void match_result(input t_outcome got);
            t_outcome want;
            if (pending_outcomes.size() == 0) begin
                report("result with nothing outstanding", 1, 0);
                return;
            end
            want = pending_outcomes.pop_front();
            if (got.best_low != want.best_low)
                report("best_low", got.best_low, want.best_low);
            if (got.best_high != want.best_high)
                report("best_high", got.best_high, want.best_high);
            if (got.coef != want.coef)
                report("gradient_coef", got.coef, want.coef);
            if (got.risk != want.risk)
                report("risk_value", got.risk, want.risk);
            if (got.pred_class != want.pred_class)
                report("predicted_class", got.pred_class, want.pred_class);
            if (got.pred_loss != want.pred_loss)
                report("prediction_loss", got.pred_loss, want.pred_loss);
            if (got.status != want.status)
                report("status", got.status, want.status);
        endfunction

        function int pending();
            return pending_outcomes.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, stimulus signals and the block
    // ------------------------------------------------------------------------
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [1:0]               i_func = '0;
    logic [LBL_W-1:0]         i_class_index = '0;
    logic signed [DAT_W-1:0]  i_beta_value = '0;
    logic signed [DAT_W-1:0]  i_wx_score = '0;
    logic [LBL_W-1:0]         i_label_low = '0;
    logic [LBL_W-1:0]         i_label_high = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [LBL_W-1:0]         o_best_low;
    logic [LBL_W-1:0]         o_best_high;
    logic signed [COEF_W-1:0] o_gradient_coef;
    logic signed [RISK_W-1:0] o_risk_value;
    logic [LBL_W-1:0]         o_predicted_class;
    logic [LBL_W-1:0]         o_prediction_loss;
    logic                     o_status;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]     i_cfg_data = '0;

    argmax_scoreboard sb = new();

    bit steady    = 1'b0;   // no idling on either side while set
    bit hold_ask  = 1'b0;   // main asks the receiver for one long stall
    bit hold_done = 1'b0;
    int hold_left = 0;

    always #2 i_clk = ~i_clk;

    interval_label_loss_augmented_argmax_top i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_func            (i_func),
        .i_class_index     (i_class_index),
        .i_beta_value      (i_beta_value),
        .i_wx_score        (i_wx_score),
        .i_label_low       (i_label_low),
        .i_label_high      (i_label_high),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_best_low        (o_best_low),
        .o_best_high       (o_best_high),
        .o_gradient_coef   (o_gradient_coef),
        .o_risk_value      (o_risk_value),
        .o_predicted_class (o_predicted_class),
        .o_prediction_loss (o_prediction_loss),
        .o_status          (o_status),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: check each accepted result, then pick next ready.
    // Values read here are the ones settled before the edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_outcome seen;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen.best_low   = o_best_low;
            seen.best_high  = o_best_high;
            seen.coef       = o_gradient_coef;
            seen.risk       = o_risk_value;
            seen.pred_class = o_predicted_class;
            seen.pred_loss  = o_prediction_loss;
            seen.status     = o_status;
            sb.match_result(seen);
        end
        if (hold_left > 0) begin
            // hold off while the sender keeps offering, so the row backs up
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_ask && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= steady || ($urandom_range(99) >= 20);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly small Q16.16 values so loss and offsets compete; some whole
    // units for ties, some full range and the two extremes.
    function automatic logic signed [DAT_W-1:0] pick_q16();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5) return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        if (roll < 25) return $urandom;
        if (roll < 45) return DAT_W'((int'($urandom_range(6)) - 3) * 65536);
        return DAT_W'(int'($urandom_range(6 * 65536)) - 3 * 65536);
    endfunction

    // Unused fields carry noise. Most evaluates and predicts get labels that
    // pass the range checks; the rest are fully random.
    function automatic t_request make_request(input int n);
        t_request    r;
        int unsigned roll;
        r.func = FN_UNUSED;
        r.cls  = LBL_W'($urandom);
        r.beta = $urandom;
        r.wx   = pick_q16();
        r.lo   = LBL_W'($urandom);
        r.hi   = LBL_W'($urandom);
        roll   = $urandom_range(99);
        if (roll < 30) begin
            r.func = FN_WRITE;
            r.beta = pick_q16();
        end else if (roll < 65) begin
            r.func = FN_EVAL;
            if ($urandom_range(99) < 85) begin
                r.hi = LBL_W'($urandom_range(n - 1));
                r.lo = LBL_W'($urandom_range(r.hi));
            end
        end else if (roll < 95) begin
            r.func = FN_PRED;
            if ($urandom_range(99) < 90) r.lo = LBL_W'($urandom_range(n - 1));
        end
        return r;
    endfunction

    // Offer one request and hold it until the block takes it. Valid stays
    // high on return so back-to-back requests need no extra edge.
    task automatic offer(input t_request r);
        i_in_valid    <= 1'b1;
        i_func        <= r.func;
        i_class_index <= r.cls;
        i_beta_value  <= r.beta;
        i_wx_score    <= r.wx;
        i_label_low   <= r.lo;
        i_label_high  <= r.hi;
        do @(posedge i_clk); while (!o_in_ready);
        sb.accept_request(r);
    endtask

    task automatic send_fields(input logic [1:0] fn, input logic [LBL_W-1:0] cls,
                               input logic signed [DAT_W-1:0] beta,
                               input logic signed [DAT_W-1:0] wx,
                               input logic [LBL_W-1:0] lo, input logic [LBL_W-1:0] hi);
        offer('{func: fn, cls: cls, beta: beta, wx: wx, lo: lo, hi: hi});
    endtask

    task automatic sender_gap();
        if (!steady && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Write both registers with the block idle: drain the results, then let the
    // block settle.
    task automatic configure(input logic [CFG_DAT_W-1:0] ncls, input logic kind);
        i_in_valid <= 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_NUM_CLASSES;
        i_cfg_data  <= ncls;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_NUM_CLASSES, ncls);
        i_cfg_index <= CFG_LOSS_KIND;
        i_cfg_data  <= CFG_DAT_W'(kind);
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(CFG_LOSS_KIND, CFG_DAT_W'(kind));
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [CFG_DAT_W-1:0] ncls_plan [PHASES];
        logic                 loss_plan [PHASES];
        t_request             r;
        int                   span, counted;

        ncls_plan = '{7'd127, 7'd2, 7'd64, 7'd23, 7'd1, 7'd64, 7'd65, 7'd9};
        loss_plan = '{LOSS_ABS, LOSS_ZERO_ONE, LOSS_ABS, LOSS_ZERO_ONE,
                      LOSS_ABS, LOSS_ZERO_ONE, LOSS_ABS, LOSS_ZERO_ONE};
        ncls_plan[3] = CFG_DAT_W'($urandom_range(2, MAX_CLASSES));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every beta entry with zero so no scan reads an unwritten one.
        for (int c = 0; c < MAX_CLASSES; c++) begin
            send_fields(FN_WRITE, LBL_W'(c), '0, '0, '0, '0);
        end

        // Directed: full ties first, both with and without the loss term.
        send_fields(FN_EVAL, '0, '0, '0, 6'd0, 6'd0);
        send_fields(FN_PRED, '0, '0, '0, 6'd17, 6'd0);
        // Extreme offsets and scores over the whole class range.
        send_fields(FN_WRITE, 6'd0, 32'sh7FFF_FFFF, '0, '0, '0);
        send_fields(FN_WRITE, 6'd63, 32'sh8000_0000, '0, '0, '0);
        send_fields(FN_EVAL, '0, '0, 32'sh7FFF_FFFF, 6'd0, 6'd63);
        send_fields(FN_EVAL, '0, '0, 32'sh8000_0000, 6'd0, 6'd63);
        send_fields(FN_EVAL, '0, '0, '0, 6'd63, 6'd63);
        // Labels out of order, then predicts at both extreme scores.
        send_fields(FN_EVAL, '0, '0, 32'sh0001_0000, 6'd40, 6'd10);
        send_fields(FN_PRED, '0, '0, 32'sh8000_0000, 6'd0, 6'd63);
        send_fields(FN_PRED, '0, '0, 32'sh7FFF_FFFF, 6'd63, 6'd0);
        // Unused function code: dropped, no result.
        send_fields(FN_UNUSED, 6'd5, 32'sh1234_5678, 32'sh0002_0000, 6'd3, 6'd4);

        // Ten classes, zero-one loss: labels at the class count and on the last class.
        configure(7'd10, LOSS_ZERO_ONE);
        send_fields(FN_EVAL, '0, '0, 32'sh0001_0000, 6'd3, 6'd10);
        send_fields(FN_PRED, '0, '0, 32'sh0001_0000, 6'd10, 6'd0);
        send_fields(FN_EVAL, '0, '0, 32'sh0001_0000, 6'd3, 6'd9);
        send_fields(FN_PRED, '0, '0, 32'shFFFF_0000, 6'd9, 6'd0);

        // Class count below the minimum clamps to two.
        configure(7'd0, LOSS_ABS);
        send_fields(FN_EVAL, '0, '0, 32'sh0000_8000, 6'd0, 6'd1);
        send_fields(FN_EVAL, '0, '0, 32'shFFFF_8000, 6'd1, 6'd1);
        send_fields(FN_PRED, '0, '0, '0, 6'd1, 6'd0);
        send_fields(FN_PRED, '0, '0, '0, 6'd2, 6'd0);

        // Random phases, one register setting each.
        for (int p = 0; p < PHASES; p++) begin
            configure(ncls_plan[p], loss_plan[p]);
            span = (ncls_plan[p] < 2) ? 2 :
                   (ncls_plan[p] > MAX_CLASSES) ? MAX_CLASSES : int'(ncls_plan[p]);
            steady = (p == 5);
            if (p == 2) hold_ask = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                r = make_request(span);
                offer(r);
                if (r.func != FN_UNUSED) counted++;
                if (p == 4 && counted == PHASE_ITEMS / 2 && r.func != FN_UNUSED) begin
                    // pause the sender until every result is back
                    i_in_valid <= 1'b0;
                    drain_results();
                end else begin
                    sender_gap();
                end
            end
        end

        i_in_valid <= 1'b0;
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog: far above the slowest correct run.
    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ilaa_pkg.sv
rtl/ilaa_cell.sv
rtl/ilaa_fin.sv
rtl/interval_label_loss_augmented_argmax_top.sv
test/tb_top.sv
